@@ sv/accel_shock_detector_unit_macros.svh @@
`ifndef ACCEL_SHOCK_DETECTOR_UNIT_MACROS_SVH
`define ACCEL_SHOCK_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASDU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASDU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/asdu_pkg.sv @@
`default_nettype none

package asdu_pkg;

	localparam int GROUP_SIZE_DEF  = 10;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int MAG_W    = 17;
	localparam int TIME_W   = 32;
	localparam int THR_W    = 13;
	localparam int HOLD_W   = 16;
	localparam int SLEEP_W  = 32;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(250);
	localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(3000);
	localparam logic [SLEEP_W-1:0] SLEEP_RESET = SLEEP_W'(300000);

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_HOLDOFF   = 2'd1,
		REG_SLEEP     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic acc;
		logic last;
	} lane_ctrl_t;

endpackage

`default_nettype wire

@@ sv/asdu_lane.sv @@
`default_nettype none

module asdu_lane import asdu_pkg::*; #(
	parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lane_ctrl_t                 ctrl,
	input  wire logic [SAMPLE_BITS-1:0]     sample,
	output logic      [2*SAMPLE_BITS-1:0]   sq
);

	localparam int SUM_W   = SAMPLE_BITS + $clog2(GROUP_SIZE);
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SUM_W) / GROUP_SIZE);

	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         sum_s1;
	logic [SUM_W-1:0]         sum_s2;
	logic [PROD_W-1:0]        prod_s2;
	logic [SAMPLE_BITS-1:0]   avg_s3;
	logic [2*SAMPLE_BITS-1:0] sq_s4;
	logic [SUM_W-1:0]         sum_next;
	logic [SAMPLE_BITS-1:0]   quot_est;
	logic [SUM_W-1:0]         quot_mul;
	logic [SUM_W-1:0]         rem;
	logic                     rem_ge;

	assign sum_next = sum_q + SUM_W'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.acc) begin
			sum_q <= ctrl.last ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc && ctrl.last) begin
			sum_s1 <= sum_next;
		end
	end

	// The reciprocal estimate is at most one below the true quotient.
	assign quot_est = prod_s2[SUM_W +: SAMPLE_BITS];
	assign quot_mul = SUM_W'(SUM_W'(quot_est) * SUM_W'(GROUP_SIZE));
	assign rem      = sum_s2 - quot_mul;
	assign rem_ge   = (rem >= SUM_W'(GROUP_SIZE));

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(sum_s1) * PROD_W'(RECIP);
		sum_s2  <= sum_s1;
		avg_s3  <= quot_est + {{(SAMPLE_BITS-1){1'b0}}, rem_ge};
		sq_s4   <= (2*SAMPLE_BITS)'(avg_s3) * (2*SAMPLE_BITS)'(avg_s3);
	end

	assign sq = sq_s4;

endmodule

`default_nettype wire

@@ sv/asdu_sqrt.sv @@
`default_nettype none

module asdu_sqrt import asdu_pkg::*; #(
	parameter int RAD_W = 4*SAMPLE_BITS_DEF + 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [RAD_W-1:0]     radicand,
	output logic                      done,
	output logic      [RAD_W/2-1:0]   root
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  rem_shift;
	logic [REM_W+1:0]  trial;
	logic              fits;

	assign rem_shift = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial     = (REM_W+2)'({root_q, 2'b01});
	assign fits      = (rem_shift >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

@@ sv/accel_shock_detector_unit.sv @@
// Three-axis shock detector. Each request on the input channel (in_valid,
// in_stall) carries one sample x_sample, y_sample, z_sample and its time_ms.
// Samples are summed per axis in three lanes; every GROUP_SIZE-th sample
// closes a group, and one result (send_event, sleep_request, magnitude) is
// offered on the output channel (out_valid, out_stall). Other samples give
// no result. Magnitude is the root of the summed squared averages, with four
// fractional bits.
// Samples that do not close a group are taken one per cycle. After the
// closing sample the input stalls while the three lanes divide and square,
// the root is started, the shared square root unit works out the root bit
// by bit, and the result is decided and loaded into the output register.
// A finished result waits in the output register while out_stall is high;
// the next samples are still taken. A new result that finds the register
// full waits in the decide step; the input stays stalled until the old one moves.
// After a sleep request all samples are taken and dropped until reset.
// Reset clears the sums, the times and the sleep flag, and restores the
// register defaults. Registers are written and read over the APB port.
`default_nettype none

module accel_shock_detector_unit import asdu_pkg::*; #(
	parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [DATA_W-1:0]      pwdata,
	output logic      [DATA_W-1:0]      prdata,
	output logic                        pready,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [SAMPLE_BITS-1:0] x_sample,
	input  wire logic [SAMPLE_BITS-1:0] y_sample,
	input  wire logic [SAMPLE_BITS-1:0] z_sample,
	input  wire logic [TIME_W-1:0]      time_ms,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        send_event,
	output logic                        sleep_request,
	output logic      [MAG_W-1:0]       magnitude
);

	localparam int SQ_W    = 2 * SAMPLE_BITS;
	localparam int SUMSQ_W = SQ_W + 2;
	localparam int RAD_W   = SUMSQ_W + 8;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int CNT_W   = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_LANES,
		ST_ROOT_START,
		ST_ROOT_WAIT,
		ST_DECIDE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         lcnt_q;
	logic [THR_W-1:0]   thr_q;
	logic [HOLD_W-1:0]  hold_q;
	logic [SLEEP_W-1:0] sleep_to_q;
	logic [MAG_W-1:0]   prev_q;
	logic [MAG_W-1:0]   mag_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  last_send_q;
	logic [TIME_W-1:0]  last_act_q;
	logic               asleep_q;
	logic               out_valid_q;
	logic               send_q;
	logic               sleep_q;
	logic [MAG_W-1:0]   out_mag_q;

	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	logic               in_take;
	logic               group_last;
	lane_ctrl_t         lane_ctrl;
	logic [SQ_W-1:0]    sq_x;
	logic [SQ_W-1:0]    sq_y;
	logic [SQ_W-1:0]    sq_z;
	logic [SUMSQ_W-1:0] sumsq;
	logic               root_start;
	logic               root_done;
	logic [ROOT_W-1:0]  root;
	logic               out_free;
	logic [MAG_W-1:0]   diff;
	logic [TIME_W-1:0]  since_send;
	logic [TIME_W-1:0]  since_act;
	logic               do_send;
	logic               do_sleep;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_THRESHOLD: prdata = DATA_W'(thr_q);
			REG_HOLDOFF:   prdata = DATA_W'(hold_q);
			REG_SLEEP:     prdata = DATA_W'(sleep_to_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RESET;
			hold_q     <= HOLD_RESET;
			sleep_to_q <= SLEEP_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_THRESHOLD: thr_q      <= pwdata[THR_W-1:0];
				REG_HOLDOFF:   hold_q     <= pwdata[HOLD_W-1:0];
				REG_SLEEP:     sleep_to_q <= pwdata[SLEEP_W-1:0];
				default:       ;
			endcase
		end
	end

	assign in_stall       = (state_q != ST_COLLECT);
	assign in_take        = in_valid && !in_stall && !asleep_q;
	assign group_last     = (cnt_q == CNT_W'(GROUP_SIZE - 1));
	assign lane_ctrl.acc  = in_take;
	assign lane_ctrl.last = group_last;

	asdu_lane #(.GROUP_SIZE(GROUP_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctrl(lane_ctrl), .sample(x_sample), .sq(sq_x)
	);

	asdu_lane #(.GROUP_SIZE(GROUP_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctrl(lane_ctrl), .sample(y_sample), .sq(sq_y)
	);

	asdu_lane #(.GROUP_SIZE(GROUP_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .ctrl(lane_ctrl), .sample(z_sample), .sq(sq_z)
	);

	assign sumsq      = SUMSQ_W'(sq_x) + SUMSQ_W'(sq_y) + SUMSQ_W'(sq_z);
	assign root_start = (state_q == ST_ROOT_START);

	asdu_sqrt #(.RAD_W(RAD_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(root_start),
		.radicand({sumsq, 8'b0}), .done(root_done), .root(root)
	);

	assign out_free   = !out_valid_q || !out_stall;
	assign diff       = (mag_q >= prev_q) ? mag_q - prev_q : prev_q - mag_q;
	assign since_send = now_q - last_send_q;
	assign since_act  = now_q - last_act_q;
	assign do_send    = (diff > {thr_q, 4'b0}) && (since_send > TIME_W'(hold_q));
	assign do_sleep   = !do_send && (since_act > sleep_to_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			cnt_q       <= '0;
			lcnt_q      <= '0;
			prev_q      <= '0;
			last_send_q <= '0;
			last_act_q  <= '0;
			asleep_q    <= 1'b0;
			out_valid_q <= 1'b0;
			send_q      <= 1'b0;
			sleep_q     <= 1'b0;
			mag_q       <= '0;
			now_q       <= '0;
			out_mag_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_DECIDE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (in_take) begin
						if (group_last) begin
							cnt_q   <= '0;
							lcnt_q  <= '0;
							now_q   <= time_ms;
							state_q <= ST_LANES;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_LANES: begin
					lcnt_q <= lcnt_q + 1'b1;
					if (lcnt_q == 2'd2) begin
						state_q <= ST_ROOT_START;
					end
				end
				ST_ROOT_START: begin
					state_q <= ST_ROOT_WAIT;
				end
				ST_ROOT_WAIT: begin
					if (root_done) begin
						mag_q   <= MAG_W'(root);
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						send_q      <= do_send;
						sleep_q     <= do_sleep;
						out_mag_q   <= mag_q;
						prev_q      <= mag_q;
						if (do_send) begin
							last_send_q <= now_q;
							last_act_q  <= now_q;
						end
						if (do_sleep) begin
							asleep_q <= 1'b1;
						end
						state_q <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign send_event    = send_q;
	assign sleep_request = sleep_q;
	assign magnitude     = out_mag_q;

endmodule

`default_nettype wire

@@ sv/asdu_chk.sv @@
`default_nettype none

`include "accel_shock_detector_unit_macros.svh"

module asdu_chk import asdu_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             send_event,
	input wire logic             sleep_request,
	input wire logic [MAG_W-1:0] magnitude
);

	`ASDU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(magnitude) && $stable(send_event) && $stable(sleep_request), "stalled result changed")
	`ASDU_ASSERT_NOW(a_send_xor_sleep, out_valid, !(send_event && sleep_request), "send and sleep in one result")
	`ASDU_ASSERT_NEXT(a_sleep_quiet, out_valid && sleep_request && !out_stall, !out_valid, "result after sleep request")

endmodule

bind accel_shock_detector_unit asdu_chk u_asdu_chk (.*);

`default_nettype wire

@@ bench/tb_accel_shock_detector_unit.sv @@
`timescale 1ns / 100ps

module tb_accel_shock_detector_unit;
	import asdu_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 600;
	localparam int SAMPLE_MAX = (1 << SAMPLE_BITS_DEF) - 1;

	typedef struct {
		logic             send;
		logic             sleep;
		logic [MAG_W-1:0] mag;
	} shock_report_t;

	// Tracks the detector state and the reports it owes, in order.
	class shock_tracker;
		logic [THR_W-1:0]   thr;
		logic [HOLD_W-1:0]  hold;
		logic [SLEEP_W-1:0] sleep_to;
		logic [31:0]        sums[3];
		int unsigned        count;
		logic [MAG_W-1:0]   prev_mag;
		logic [TIME_W-1:0]  last_send;
		logic [TIME_W-1:0]  last_act;
		bit                 asleep;
		shock_report_t      pending_reports[$];
		int unsigned        mismatches;

		function new();
			thr = THR_RESET;
			hold = HOLD_RESET;
			sleep_to = SLEEP_RESET;
			foreach (sums[a]) sums[a] = '0;
			count = 0;
			prev_mag = '0;
			last_send = '0;
			last_act = '0;
			asleep = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_THRESHOLD: thr = value[THR_W-1:0];
				REG_HOLDOFF: hold = value[HOLD_W-1:0];
				REG_SLEEP: sleep_to = value[SLEEP_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [MAG_W-1:0] root_x16(logic [63:0] sq);
			logic [17:0] r;
			logic [17:0] t;
			r = '0;
			for (int b = 17; b >= 0; b--) begin
				t = r | (18'd1 << b);
				if (64'(t) * 64'(t) <= sq)
					r = t;
			end
			return r[MAG_W-1:0];
		endfunction

		function void take_sample(logic [SAMPLE_BITS_DEF-1:0] xs, logic [SAMPLE_BITS_DEF-1:0] ys,
				logic [SAMPLE_BITS_DEF-1:0] zs, logic [TIME_W-1:0] ts);
			logic [63:0] sumsq;
			logic [63:0] avg;
			logic [MAG_W-1:0] mag;
			logic [MAG_W-1:0] diff;
			shock_report_t rep;
			if (asleep)
				return;
			sums[0] += xs;
			sums[1] += ys;
			sums[2] += zs;
			count++;
			if (count < GROUP_SIZE_DEF)
				return;
			sumsq = '0;
			for (int a = 0; a < 3; a++) begin
				avg = 64'(sums[a] / GROUP_SIZE_DEF);
				sumsq += avg * avg;
				sums[a] = '0;
			end
			count = 0;
			mag = root_x16(sumsq << 8);
			diff = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
			prev_mag = mag;
			rep.send = 1'b0;
			rep.sleep = 1'b0;
			rep.mag = mag;
			if (32'(diff) > 32'(thr) * 16 && ts - last_send > 32'(hold)) begin
				rep.send = 1'b1;
				last_send = ts;
				last_act = ts;
			end
			if (ts - last_act > sleep_to) begin
				rep.sleep = 1'b1;
				asleep = 1'b1;
			end
			pending_reports.push_back(rep);
		endfunction

		function void check_report(logic send, logic sleep, logic [MAG_W-1:0] mag);
			shock_report_t exp_rep;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: send=%0d sleep=%0d mag=%0d", send, sleep, mag);
				return;
			end
			exp_rep = pending_reports.pop_front();
			if (send !== exp_rep.send || sleep !== exp_rep.sleep || mag !== exp_rep.mag) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected send=%0d sleep=%0d mag=%0d, got send=%0d sleep=%0d mag=%0d",
						exp_rep.send, exp_rep.sleep, exp_rep.mag, send, sleep, mag);
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ADDR_W-1:0]          paddr;
	logic [DATA_W-1:0]          pwdata;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_stall;
	logic [SAMPLE_BITS_DEF-1:0] x_sample;
	logic [SAMPLE_BITS_DEF-1:0] y_sample;
	logic [SAMPLE_BITS_DEF-1:0] z_sample;
	logic [TIME_W-1:0]          time_ms;
	logic                       out_valid;
	logic                       out_stall;
	logic                       send_event;
	logic                       sleep_request;
	logic [MAG_W-1:0]           magnitude;

	shock_tracker tracker;
	int unsigned  quiet_cycles;
	bit           hold_off_req;
	bit           burst;
	int unsigned  group_pos;
	int unsigned  group_mode;
	int           lvl[3];
	logic [31:0]  ms_now;

	accel_shock_detector_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_sample(x_sample),
		.y_sample(y_sample),
		.z_sample(z_sample),
		.time_ms(time_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.send_event(send_event),
		.sleep_request(sleep_request),
		.magnitude(magnitude)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_report(send_event, sleep_request, magnitude);
			if (in_valid && !in_stall)
				tracker.take_sample(x_sample, y_sample, z_sample, time_ms);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("accel_shock_detector_unit verification failed");
					$finish;
				end
			end
		end
	end

	// The receiver stalls at random; on request it holds off for a long stretch.
	initial begin
		int unsigned draw;
		out_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				draw = $urandom_range(0, 99);
				if (draw < 40) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 30)) @(posedge clk);
				end else if (draw < 90) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(10, 50)) @(posedge clk);
				end
			end
		end
	end

	function automatic logic [31:0] next_ms();
		if ($urandom_range(0, 99) < 5)
			ms_now += $urandom_range(60000, 70000);
		else
			ms_now += $urandom_range(0, 2000);
		return ms_now;
	endfunction

	task automatic offer_sample(input logic [SAMPLE_BITS_DEF-1:0] xv,
			input logic [SAMPLE_BITS_DEF-1:0] yv, input logic [SAMPLE_BITS_DEF-1:0] zv,
			input logic [TIME_W-1:0] tv);
		int unsigned draw;
		int unsigned gap;
		draw = $urandom_range(0, 99);
		if (burst || draw < 55)
			gap = 0;
		else if (draw < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_sample <= xv;
		y_sample <= yv;
		z_sample <= zv;
		time_ms <= tv;
		do @(posedge clk); while (in_stall);
		group_pos = (group_pos + 1) % GROUP_SIZE_DEF;
	endtask

	task automatic offer_random(input int unsigned count);
		int v[3];
		for (int n = 0; n < count; n++) begin
			if (group_pos == 0) begin
				group_mode = $urandom_range(0, 99);
				foreach (lvl[a]) lvl[a] = $urandom_range(0, SAMPLE_MAX);
				burst = ($urandom_range(0, 3) == 0);
			end
			for (int a = 0; a < 3; a++) begin
				if (group_mode < 70) begin
					v[a] = lvl[a] + int'($urandom_range(0, 100)) - 50;
					if (v[a] < 0)
						v[a] = 0;
					if (v[a] > SAMPLE_MAX)
						v[a] = SAMPLE_MAX;
				end else if (group_mode < 85) begin
					v[a] = $urandom_range(0, SAMPLE_MAX);
				end else begin
					v[a] = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
				end
			end
			offer_sample(SAMPLE_BITS_DEF'(v[0]), SAMPLE_BITS_DEF'(v[1]),
				SAMPLE_BITS_DEF'(v[2]), next_ms());
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_reg(idx, value);
		@(posedge clk);
	endtask

	initial begin
		tracker = new();
		quiet_cycles = 0;
		hold_off_req = 1'b0;
		burst = 1'b0;
		group_pos = 0;
		group_mode = 0;
		ms_now = '0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		x_sample = '0;
		y_sample = '0;
		z_sample = '0;
		time_ms = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-scale group against a zero previous magnitude, then a drop
		// to zero that the hold-off suppresses.
		for (int n = 0; n < 10; n++)
			offer_sample(SAMPLE_BITS_DEF'(SAMPLE_MAX), SAMPLE_BITS_DEF'(SAMPLE_MAX),
				SAMPLE_BITS_DEF'(SAMPLE_MAX), 32'd5000 + n);
		for (int n = 0; n < 10; n++)
			offer_sample('0, '0, '0, 32'd6000 + n);
		settle();

		// Time runs through the 32-bit wrap with no threshold and no hold-off.
		write_reg(REG_THRESHOLD, '0);
		write_reg(REG_HOLDOFF, '0);
		write_reg(REG_SLEEP, '1);
		ms_now = 32'hFFFF_FFFF - $urandom_range(10000, 60000);
		offer_random($urandom_range(85, 115));

		for (int p = 2; p <= 6; p++) begin
			settle();
			if (p == 2)
				write_reg(REG_THRESHOLD, 8191);
			else if (p == 5)
				write_reg(REG_THRESHOLD, $urandom());
			else
				write_reg(REG_THRESHOLD, $urandom_range(0, 1500));
			if (p == 3)
				write_reg(REG_HOLDOFF, 65535);
			else if (p == 5)
				write_reg(REG_HOLDOFF, $urandom());
			else
				write_reg(REG_HOLDOFF, $urandom_range(0, 20000));
			write_reg(REG_SLEEP, $urandom_range(8000000, 32'hFFFF_FFFE));
			if (p == 4)
				hold_off_req = 1'b1;
			offer_random($urandom_range(85, 115));
		end

		settle();
		write_reg(REG_SLEEP, '1);
		write_reg(REG_THRESHOLD, '0);
		write_reg(REG_HOLDOFF, '0);
		while (group_pos != 0)
			offer_sample('0, '0, '0, next_ms());
		for (int n = 0; n < 10; n++)
			offer_sample('0, '0, '0, ms_now);
		settle();

		// With a zero timeout a send still keeps the block awake; the next
		// quiet group puts it to sleep and later samples are dropped.
		write_reg(REG_SLEEP, '0);
		for (int n = 0; n < 10; n++)
			offer_sample(SAMPLE_BITS_DEF'(SAMPLE_MAX), SAMPLE_BITS_DEF'(SAMPLE_MAX),
				SAMPLE_BITS_DEF'(SAMPLE_MAX), ms_now + 5);
		for (int n = 0; n < 10; n++)
			offer_sample(SAMPLE_BITS_DEF'(SAMPLE_MAX), SAMPLE_BITS_DEF'(SAMPLE_MAX),
				SAMPLE_BITS_DEF'(SAMPLE_MAX), ms_now + 8);
		for (int n = 0; n < 20; n++)
			offer_sample(SAMPLE_BITS_DEF'($urandom_range(0, SAMPLE_MAX)),
				SAMPLE_BITS_DEF'($urandom_range(0, SAMPLE_MAX)),
				SAMPLE_BITS_DEF'($urandom_range(0, SAMPLE_MAX)), $urandom());
		settle();

		if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0)
			$display("accel_shock_detector_unit verification clean");
		else
			$display("accel_shock_detector_unit verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/asdu_pkg.sv
sv/asdu_lane.sv
sv/asdu_sqrt.sv
sv/accel_shock_detector_unit.sv
sv/asdu_chk.sv
bench/tb_accel_shock_detector_unit.sv
